// ===== hw/rtl/nicd_pkg.sv =====
// ============================================================================
// nicd_pkg
// Shared types, codes and constants of the NiCd charge controller.
// ============================================================================
`default_nettype none

package nicd_pkg;

  // Field widths.
  localparam int unsigned MvW    = 14;
  localparam int unsigned MaW    = 12;
  localparam int unsigned CountW = 4;
  localparam int unsigned CellsW = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] RegRemovalLow = 3'd0;
  localparam logic [2:0] RegRemovalHigh = 3'd1;
  localparam logic [2:0] RegPresence = 3'd2;
  localparam logic [2:0] RegPreCurrent = 3'd3;
  localparam logic [2:0] RegFastCurrent = 3'd4;
  localparam logic [2:0] RegStackPreCurrent = 3'd5;
  localparam logic [2:0] RegStackFastCurrent = 3'd6;
  localparam logic [2:0] RegDvCountLimit = 3'd7;

  // Register reset values.
  localparam logic [MvW-1:0]    RemovalLowReset = 14'd50;
  localparam logic [MvW-1:0]    RemovalHighReset = 14'd5100;
  localparam logic [MvW-1:0]    PresenceReset = 14'd500;
  localparam logic [MaW-1:0]    PreCurrentReset = 12'd350;
  localparam logic [MaW-1:0]    FastCurrentReset = 12'd1600;
  localparam logic [MaW-1:0]    StackPreCurrentReset = 12'd30;
  localparam logic [MaW-1:0]    StackFastCurrentReset = 12'd80;
  localparam logic [CountW-1:0] DvCountLimitReset = 4'd3;

  // Fixed thresholds in millivolts and milliamperes.
  localparam logic [10:0]       PreChargeMvPerCell = 11'd1280;
  localparam logic [10:0]       RestartMvPerCell = 11'd1320;
  localparam logic [MvW-1:0]    SingleCellMaxMv = 14'd1500;
  localparam logic [MvW-1:0]    ArrayMinMv = 14'd2000;
  localparam logic [MvW-1:0]    FourCellMinMv = 14'd4000;
  localparam logic [MvW-1:0]    SevenCellMinMv = 14'd7000;
  localparam logic [MvW-1:0]    CurrentTolMa = 14'd30;
  localparam logic [CountW-1:0] DvThresholdSmallMv = 4'd10;
  localparam logic [CountW-1:0] DvThresholdLargeMv = 4'd8;
  localparam logic [CountW-1:0] DvCountMax = 4'd15;

  localparam logic [CellsW-1:0] CellsNone = 3'd0;
  localparam logic [CellsW-1:0] CellsOne = 3'd1;
  localparam logic [CellsW-1:0] CellsTwo = 3'd2;
  localparam logic [CellsW-1:0] CellsFour = 3'd4;
  localparam logic [CellsW-1:0] CellsSeven = 3'd7;

  typedef enum logic [2:0] {
    StageDetectCell  = 3'd0,
    StageDetectType  = 3'd1,
    StageDetectArray = 3'd2,
    StageCharging    = 3'd3,
    StageStop        = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    KindUnknown = 2'd0,
    KindSingle  = 2'd1,
    KindArray   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhasePre  = 2'd1,
    PhaseFast = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PwmKeep   = 2'd0,
    PwmZero   = 2'd1,
    PwmDetect = 2'd2
  } pwm_e;

  typedef struct packed {
    logic [MvW-1:0]    removal_low_mv;
    logic [MvW-1:0]    removal_high_mv;
    logic [MvW-1:0]    presence_mv;
    logic [MaW-1:0]    pre_current_ma;
    logic [MaW-1:0]    fast_current_ma;
    logic [MaW-1:0]    stack_pre_current_ma;
    logic [MaW-1:0]    stack_fast_current_ma;
    logic [CountW-1:0] dv_count_limit;
  } cfg_t;

  typedef struct packed {
    stage_e            stage;
    kind_e             kind;
    logic [CellsW-1:0] cells;
    phase_e            phase;
    logic [MaW-1:0]    target_ma;
    logic [MvW-1:0]    peak_mv;
    logic [CountW-1:0] dv_count;
    logic [MvW-1:0]    rest_mv;
  } state_t;

  typedef struct packed {
    stage_e            stage;
    kind_e             kind;
    logic [CellsW-1:0] cells;
    phase_e            phase;
    logic [MaW-1:0]    target_ma;
    logic              adjust;
    pwm_e              pwm;
    logic [MvW-1:0]    peak_mv;
    logic [CountW-1:0] dv_count;
  } result_t;

  // Per-pack voltage limit: cell count times a per-cell figure.
  function automatic logic [MvW-1:0] pack_limit(logic [CellsW-1:0] cells,
                                                logic [10:0] per_cell);
    logic [MvW-1:0] prod;
    prod = MvW'(cells) * MvW'(per_cell);
    return prod;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nicd_regs.sv =====
// ============================================================================
// nicd_regs
// Configuration register file behind the APB-style port.
// ============================================================================
`default_nettype none

module nicd_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nicd_pkg::AddrW-1:0]  paddr,
  input  wire logic [nicd_pkg::DataW-1:0]  pwdata,
  output logic      [nicd_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output nicd_pkg::cfg_t                   cfg_o
);

  nicd_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.removal_low_mv        <= nicd_pkg::RemovalLowReset;
      cfg_q.removal_high_mv       <= nicd_pkg::RemovalHighReset;
      cfg_q.presence_mv           <= nicd_pkg::PresenceReset;
      cfg_q.pre_current_ma        <= nicd_pkg::PreCurrentReset;
      cfg_q.fast_current_ma       <= nicd_pkg::FastCurrentReset;
      cfg_q.stack_pre_current_ma  <= nicd_pkg::StackPreCurrentReset;
      cfg_q.stack_fast_current_ma <= nicd_pkg::StackFastCurrentReset;
      cfg_q.dv_count_limit        <= nicd_pkg::DvCountLimitReset;
    end else if (wr_en) begin
      case (reg_idx)
        nicd_pkg::RegRemovalLow:       cfg_q.removal_low_mv <= pwdata[13:0];
        nicd_pkg::RegRemovalHigh:      cfg_q.removal_high_mv <= pwdata[13:0];
        nicd_pkg::RegPresence:         cfg_q.presence_mv <= pwdata[13:0];
        nicd_pkg::RegPreCurrent:       cfg_q.pre_current_ma <= pwdata[11:0];
        nicd_pkg::RegFastCurrent:      cfg_q.fast_current_ma <= pwdata[11:0];
        nicd_pkg::RegStackPreCurrent:  cfg_q.stack_pre_current_ma <= pwdata[11:0];
        nicd_pkg::RegStackFastCurrent: cfg_q.stack_fast_current_ma <= pwdata[11:0];
        nicd_pkg::RegDvCountLimit:     cfg_q.dv_count_limit <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nicd_pkg::RegRemovalLow:       prdata = 32'(cfg_q.removal_low_mv);
      nicd_pkg::RegRemovalHigh:      prdata = 32'(cfg_q.removal_high_mv);
      nicd_pkg::RegPresence:         prdata = 32'(cfg_q.presence_mv);
      nicd_pkg::RegPreCurrent:       prdata = 32'(cfg_q.pre_current_ma);
      nicd_pkg::RegFastCurrent:      prdata = 32'(cfg_q.fast_current_ma);
      nicd_pkg::RegStackPreCurrent:  prdata = 32'(cfg_q.stack_pre_current_ma);
      nicd_pkg::RegStackFastCurrent: prdata = 32'(cfg_q.stack_fast_current_ma);
      nicd_pkg::RegDvCountLimit:     prdata = 32'(cfg_q.dv_count_limit);
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nicd_step.sv =====
// ============================================================================
// nicd_step
// Next-state and result logic for one measurement tick.
// ============================================================================
`default_nettype none

module nicd_step (
  input  wire nicd_pkg::cfg_t                cfg_i,
  input  wire nicd_pkg::state_t              state_i,
  input  wire logic [nicd_pkg::MvW-1:0]      voltage_mv_i,
  input  wire logic [nicd_pkg::MaW-1:0]      current_mv_ma_i,
  input  wire logic [nicd_pkg::MvW-1:0]      rest_voltage_mv_i,
  output nicd_pkg::state_t                   state_o,
  output nicd_pkg::result_t                  result_o
);

  nicd_pkg::state_t          st;
  nicd_pkg::pwm_e            pwm;
  logic                      adjust;
  logic [nicd_pkg::MvW-1:0]  cur_ext;
  logic [nicd_pkg::MvW-1:0]  tgt_ext;
  logic [nicd_pkg::CountW-1:0] dv_th;

  assign cur_ext = {2'b00, current_mv_ma_i};

  always_comb begin
    st     = state_i;
    pwm    = nicd_pkg::PwmKeep;
    adjust = 1'b0;
    tgt_ext = '0;
    dv_th   = nicd_pkg::DvThresholdSmallMv;

    // Cell pulled out: start over from presence detection.
    if (voltage_mv_i <= cfg_i.removal_low_mv || voltage_mv_i >= cfg_i.removal_high_mv) begin
      st.stage     = nicd_pkg::StageDetectCell;
      st.kind      = nicd_pkg::KindUnknown;
      st.cells     = nicd_pkg::CellsNone;
      st.phase     = nicd_pkg::PhaseIdle;
      st.target_ma = '0;
      st.peak_mv   = '0;
      st.dv_count  = '0;
      st.rest_mv   = '0;
      pwm          = nicd_pkg::PwmZero;
    end

    if (st.stage == nicd_pkg::StageCharging) begin
      if (st.rest_mv < nicd_pkg::pack_limit(st.cells, nicd_pkg::PreChargeMvPerCell)) begin
        st.target_ma = (st.cells == nicd_pkg::CellsSeven) ? cfg_i.stack_pre_current_ma
                                                          : cfg_i.pre_current_ma;
        st.phase     = nicd_pkg::PhasePre;
        st.rest_mv   = rest_voltage_mv_i;
      end else if (st.phase != nicd_pkg::PhaseFast) begin
        st.target_ma = (st.cells == nicd_pkg::CellsSeven) ? cfg_i.stack_fast_current_ma
                                                          : cfg_i.fast_current_ma;
        st.phase     = nicd_pkg::PhaseFast;
        adjust       = 1'b1;
      end

      if (st.phase != nicd_pkg::PhaseFast) begin
        tgt_ext = {2'b00, st.target_ma};
        if (cur_ext > tgt_ext + nicd_pkg::CurrentTolMa ||
            cur_ext + nicd_pkg::CurrentTolMa < tgt_ext) begin
          adjust = 1'b1;
        end
      end else begin
        dv_th = (st.cells > nicd_pkg::CellsTwo) ? nicd_pkg::DvThresholdLargeMv
                                               : nicd_pkg::DvThresholdSmallMv;
        if (voltage_mv_i > st.peak_mv) begin
          st.peak_mv  = voltage_mv_i;
          st.dv_count = '0;
        end
        if ({1'b0, st.peak_mv} > {1'b0, voltage_mv_i} + 15'(dv_th)) begin
          if (st.dv_count != nicd_pkg::DvCountMax) begin
            st.dv_count = st.dv_count + 4'd1;
          end
          if (st.dv_count > cfg_i.dv_count_limit) begin
            st.stage = nicd_pkg::StageStop;
            pwm      = nicd_pkg::PwmZero;
          end
        end
      end
    end

    case (st.stage)
      nicd_pkg::StageDetectCell: begin
        if (voltage_mv_i < cfg_i.presence_mv) begin
          pwm = nicd_pkg::PwmDetect;
        end else begin
          st.stage = nicd_pkg::StageDetectType;
          pwm      = nicd_pkg::PwmZero;
        end
      end
      nicd_pkg::StageDetectType: begin
        pwm = nicd_pkg::PwmZero;
        if (voltage_mv_i < nicd_pkg::SingleCellMaxMv) begin
          st.kind  = nicd_pkg::KindSingle;
          st.cells = nicd_pkg::CellsOne;
          st.stage = nicd_pkg::StageCharging;
        end else if (voltage_mv_i >= nicd_pkg::ArrayMinMv) begin
          st.kind  = nicd_pkg::KindArray;
          st.cells = nicd_pkg::CellsTwo;
          st.stage = nicd_pkg::StageDetectArray;
        end
      end
      nicd_pkg::StageDetectArray: begin
        pwm = nicd_pkg::PwmZero;
        if (voltage_mv_i >= nicd_pkg::SevenCellMinMv) begin
          st.cells = nicd_pkg::CellsSeven;
          st.stage = nicd_pkg::StageCharging;
        end else if (voltage_mv_i >= nicd_pkg::FourCellMinMv) begin
          st.cells = nicd_pkg::CellsFour;
          st.stage = nicd_pkg::StageCharging;
        end else if (voltage_mv_i >= nicd_pkg::ArrayMinMv) begin
          st.cells = nicd_pkg::CellsTwo;
          st.stage = nicd_pkg::StageCharging;
        end else begin
          st.kind  = nicd_pkg::KindUnknown;
          st.cells = nicd_pkg::CellsNone;
          st.stage = nicd_pkg::StageStop;
        end
      end
      nicd_pkg::StageStop: begin
        pwm        = nicd_pkg::PwmZero;
        st.rest_mv = rest_voltage_mv_i;
        if (st.rest_mv < nicd_pkg::pack_limit(st.cells, nicd_pkg::RestartMvPerCell)) begin
          st.stage = nicd_pkg::StageCharging;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = st;

  assign result_o.stage     = st.stage;
  assign result_o.kind      = st.kind;
  assign result_o.cells     = st.cells;
  assign result_o.phase     = st.phase;
  assign result_o.target_ma = st.target_ma;
  assign result_o.adjust    = adjust;
  assign result_o.pwm       = pwm;
  assign result_o.peak_mv   = st.peak_mv;
  assign result_o.dv_count  = st.dv_count;

endmodule

`default_nettype wire

// ===== hw/rtl/nicd_charge_controller.sv =====
// ============================================================================
// nicd_charge_controller
// NiCd charger sequencer with negative-delta-V charge termination.
// ============================================================================
// Each accepted input beat is one measurement tick (pack voltage, charge
// current and a rest-voltage sample) and produces exactly one result beat with
// the stage, cell kind, pack size, charge phase, current target, an
// adjust request, a PWM action, the fast-charge peak voltage and the -dV count.
// The block has two registered stages: an input register that captures the
// tick, and a result register loaded by the charge logic, which also updates
// the controller state in the same cycle. A tick can therefore be accepted in
// every cycle while the output side is not stalled, and its result is loaded
// from the charge logic into the result register. The result register
// and the input register each hold one beat, so while a finished result waits
// to be taken the input stays ready only if the input register is empty; a
// held tick behind a waiting result stalls the input until the result goes.
// Thresholds and charge currents are set through the APB-style port at byte
// address 4 * index and should only be changed while no tick is in flight.
// ============================================================================
`default_nettype none

module nicd_charge_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nicd_pkg::AddrW-1:0]    paddr,
  input  wire logic [nicd_pkg::DataW-1:0]    pwdata,
  output logic      [nicd_pkg::DataW-1:0]    prdata,
  output logic                               pready,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [nicd_pkg::MvW-1:0]      voltage_mv_i,
  input  wire logic [nicd_pkg::MaW-1:0]      current_mv_ma_i,
  input  wire logic [nicd_pkg::MvW-1:0]      rest_voltage_mv_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         stage_o,
  output logic [1:0]                         cell_kind_o,
  output logic [nicd_pkg::CellsW-1:0]        pack_cells_o,
  output logic [1:0]                         charge_phase_o,
  output logic [nicd_pkg::MaW-1:0]           target_ma_o,
  output logic                               adjust_request_o,
  output logic [1:0]                         pwm_action_o,
  output logic [nicd_pkg::MvW-1:0]           peak_mv_o,
  output logic [nicd_pkg::CountW-1:0]        dv_count_o
);

  nicd_pkg::cfg_t    cfg;
  nicd_pkg::state_t  state_q;
  nicd_pkg::state_t  state_d;
  nicd_pkg::result_t result_d;
  nicd_pkg::result_t result_q;

  logic                      in_valid_q;
  logic [nicd_pkg::MvW-1:0]  voltage_q;
  logic [nicd_pkg::MaW-1:0]  current_q;
  logic [nicd_pkg::MvW-1:0]  rest_q;
  logic                      out_valid_q;
  logic                      out_free;
  logic                      step_fire;
  logic                      in_fire;

  nicd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nicd_step u_step (
    .cfg_i             (cfg),
    .state_i           (state_q),
    .voltage_mv_i      (voltage_q),
    .current_mv_ma_i   (current_q),
    .rest_voltage_mv_i (rest_q),
    .state_o           (state_d),
    .result_o          (result_d)
  );

  // The result register can take a new beat when it is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  // The held tick is processed, and the state advances, when its result fits.
  assign step_fire  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      voltage_q <= voltage_mv_i;
      current_q <= current_mv_ma_i;
      rest_q    <= rest_voltage_mv_i;
    end
    if (step_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stage_o          = result_q.stage;
  assign cell_kind_o      = result_q.kind;
  assign pack_cells_o     = result_q.cells;
  assign charge_phase_o   = result_q.phase;
  assign target_ma_o      = result_q.target_ma;
  assign adjust_request_o = result_q.adjust;
  assign pwm_action_o     = result_q.pwm;
  assign peak_mv_o        = result_q.peak_mv;
  assign dv_count_o       = result_q.dv_count;

endmodule

`default_nettype wire

// ===== dv/nicd_charge_controller_test.sv =====
// ============================================================================
// nicd_charge_controller_test
// Self-checking testbench of the NiCd charge sequencer with -dV termination.
// ============================================================================
// A queue of measurement ticks feeds a valid/ready driver. Every accepted
// tick runs through a behavioral predictor of the charger. The predictor
// pushes the expected result beat, and a monitor compares each result beat
// field by field. The stimulus is a directed walk through every stage but
// array sizing, followed by mostly well-formed charge sessions with random
// content, mixed with random noise ticks. The sessions run under several
// register settings, the extremes among them.
// ============================================================================

module nicd_charge_controller_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Thresholds of the charger, kept apart from the design's own constants.
  localparam int PreMvPerCell     = 1280;
  localparam int RestartMvPerCell = 1320;
  localparam int SingleMaxMv      = 1500;
  localparam int ArrayMinMv       = 2000;
  localparam int FourMinMv        = 4000;
  localparam int SevenMinMv       = 7000;
  localparam int TolMa            = 30;
  localparam int DvStepSmallPack  = 10;
  localparam int DvStepBigPack    = 8;
  localparam int MaxMv            = 16383;
  localparam int MaxMa            = 4095;
  localparam int IdlePercent      = 26;
  localparam int LimitCycles      = 200000;

  typedef struct packed {
    logic [nicd_pkg::MvW-1:0] mv;
    logic [nicd_pkg::MaW-1:0] ma;
    logic [nicd_pkg::MvW-1:0] rest_mv;
  } tick_t;

  // Clock, reset and every block input start at known values.
  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        psel              = 1'b0;
  logic                        penable           = 1'b0;
  logic                        pwrite            = 1'b0;
  logic [nicd_pkg::AddrW-1:0]  paddr             = '0;
  logic [nicd_pkg::DataW-1:0]  pwdata            = '0;
  logic [nicd_pkg::DataW-1:0]  prdata;
  logic                        pready;
  logic                        in_valid_i        = 1'b0;
  logic                        in_ready_o;
  logic [nicd_pkg::MvW-1:0]    voltage_mv_i      = '0;
  logic [nicd_pkg::MaW-1:0]    current_mv_ma_i   = '0;
  logic [nicd_pkg::MvW-1:0]    rest_voltage_mv_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i       = 1'b0;
  logic [2:0]                  stage_o;
  logic [1:0]                  cell_kind_o;
  logic [nicd_pkg::CellsW-1:0] pack_cells_o;
  logic [1:0]                  charge_phase_o;
  logic [nicd_pkg::MaW-1:0]    target_ma_o;
  logic                        adjust_request_o;
  logic [1:0]                  pwm_action_o;
  logic [nicd_pkg::MvW-1:0]    peak_mv_o;
  logic [nicd_pkg::CountW-1:0] dv_count_o;

  nicd_charge_controller i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .voltage_mv_i      (voltage_mv_i),
    .current_mv_ma_i   (current_mv_ma_i),
    .rest_voltage_mv_i (rest_voltage_mv_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .stage_o           (stage_o),
    .cell_kind_o       (cell_kind_o),
    .pack_cells_o      (pack_cells_o),
    .charge_phase_o    (charge_phase_o),
    .target_ma_o       (target_ma_o),
    .adjust_request_o  (adjust_request_o),
    .pwm_action_o      (pwm_action_o),
    .peak_mv_o         (peak_mv_o),
    .dv_count_o        (dv_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Ticks waiting to be sent, and the result beats the charger model predicts.
  tick_t             tick_q[$];
  nicd_pkg::result_t pending_reports[$];
  int                queued_ticks   = 0;
  int                mismatch_count = 0;
  int                cycle_count    = 0;
  // While calm is set, neither side idles.
  bit                calm           = 1'b0;

  // The charger model's copy of the registers and of the controller state.
  nicd_pkg::cfg_t              cfg;
  nicd_pkg::stage_e            m_stage;
  nicd_pkg::kind_e             m_kind;
  logic [nicd_pkg::CellsW-1:0] m_cells;
  nicd_pkg::phase_e            m_phase;
  logic [nicd_pkg::MaW-1:0]    m_target;
  logic [nicd_pkg::MvW-1:0]    m_peak;
  logic [nicd_pkg::CountW-1:0] m_dv;
  logic [nicd_pkg::MvW-1:0]    m_rest;

  task automatic clear_charger();
    m_stage  = nicd_pkg::StageDetectCell;
    m_kind   = nicd_pkg::KindUnknown;
    m_cells  = nicd_pkg::CellsNone;
    m_phase  = nicd_pkg::PhaseIdle;
    m_target = '0;
    m_peak   = '0;
    m_dv     = '0;
    m_rest   = '0;
  endtask

  // One measurement tick of the charger: removal check first, then the
  // charge-mode logic, then the handler of the stage that results. When
  // several PWM actions occur in one tick, the last one wins.
  task automatic step_charger(input tick_t t, output nicd_pkg::result_t r);
    nicd_pkg::pwm_e pwm;
    logic adj;
    int   vi;
    int   ci;
    int   ti;
    int   step;
    pwm = nicd_pkg::PwmKeep;
    adj = 1'b0;
    vi  = t.mv;
    ci  = t.ma;
    if (t.mv <= cfg.removal_low_mv || t.mv >= cfg.removal_high_mv) begin
      clear_charger();
      pwm = nicd_pkg::PwmZero;
    end
    if (m_stage == nicd_pkg::StageCharging) begin
      if (int'(m_rest) < PreMvPerCell * int'(m_cells)) begin
        m_target = (m_cells == nicd_pkg::CellsSeven) ? cfg.stack_pre_current_ma
                                                     : cfg.pre_current_ma;
        m_phase  = nicd_pkg::PhasePre;
        m_rest   = t.rest_mv;
      end else if (m_phase != nicd_pkg::PhaseFast) begin
        // The tick that enters fast charge always asks for a current servo.
        m_target = (m_cells == nicd_pkg::CellsSeven) ? cfg.stack_fast_current_ma
                                                     : cfg.fast_current_ma;
        m_phase  = nicd_pkg::PhaseFast;
        adj      = 1'b1;
      end
      if (m_phase != nicd_pkg::PhaseFast) begin
        ti = m_target;
        if (ci > ti + TolMa || ci < ti - TolMa) adj = 1'b1;
      end else begin
        // Packs over two cells use the finer -dV step.
        step = (m_cells > nicd_pkg::CellsTwo) ? DvStepBigPack : DvStepSmallPack;
        if (t.mv > m_peak) begin
          m_peak = t.mv;
          m_dv   = '0;
        end
        if (int'(m_peak) > vi + step) begin
          if (m_dv != 4'd15) m_dv = m_dv + 4'd1;
          if (m_dv > cfg.dv_count_limit) begin
            m_stage = nicd_pkg::StageStop;
            pwm     = nicd_pkg::PwmZero;
          end
        end
      end
    end
    case (m_stage)
      nicd_pkg::StageDetectCell: begin
        if (t.mv < cfg.presence_mv) begin
          pwm = nicd_pkg::PwmDetect;
        end else begin
          m_stage = nicd_pkg::StageDetectType;
          pwm     = nicd_pkg::PwmZero;
        end
      end
      nicd_pkg::StageDetectType: begin
        pwm = nicd_pkg::PwmZero;
        if (vi < SingleMaxMv) begin
          m_kind  = nicd_pkg::KindSingle;
          m_cells = nicd_pkg::CellsOne;
          m_stage = nicd_pkg::StageCharging;
        end else if (vi >= ArrayMinMv) begin
          m_kind  = nicd_pkg::KindArray;
          m_cells = nicd_pkg::CellsTwo;
          m_stage = nicd_pkg::StageDetectArray;
        end
      end
      nicd_pkg::StageDetectArray: begin
        pwm = nicd_pkg::PwmZero;
        if (vi >= SevenMinMv) begin
          m_cells = nicd_pkg::CellsSeven;
          m_stage = nicd_pkg::StageCharging;
        end else if (vi >= FourMinMv) begin
          m_cells = nicd_pkg::CellsFour;
          m_stage = nicd_pkg::StageCharging;
        end else if (vi >= ArrayMinMv) begin
          m_cells = nicd_pkg::CellsTwo;
          m_stage = nicd_pkg::StageCharging;
        end else begin
          m_kind  = nicd_pkg::KindUnknown;
          m_cells = nicd_pkg::CellsNone;
          m_stage = nicd_pkg::StageStop;
        end
      end
      nicd_pkg::StageStop: begin
        pwm    = nicd_pkg::PwmZero;
        m_rest = t.rest_mv;
        // Restart keeps the phase, the peak and the -dV count.
        if (int'(m_rest) < RestartMvPerCell * int'(m_cells)) begin
          m_stage = nicd_pkg::StageCharging;
        end
      end
      default: begin
      end
    endcase
    r.stage     = m_stage;
    r.kind      = m_kind;
    r.cells     = m_cells;
    r.phase     = m_phase;
    r.target_ma = m_target;
    r.adjust    = adj;
    r.pwm       = pwm;
    r.peak_mv   = m_peak;
    r.dv_count  = m_dv;
  endtask

  // Driver: one beat at a time from tick_q. A beat that is offered stays put
  // until it is taken, and the model is stepped at the edge that takes it.
  always @(posedge clk_i) begin : drive_ticks
    tick_t             t;
    nicd_pkg::result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        t.mv      = voltage_mv_i;
        t.ma      = current_mv_ma_i;
        t.rest_mv = rest_voltage_mv_i;
        step_charger(t, r);
        pending_reports.push_back(r);
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the beat; nothing changes.
      end else if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        t = tick_q.pop_front();
        in_valid_i        <= 1'b1;
        voltage_mv_i      <= t.mv;
        current_mv_ma_i   <= t.ma;
        rest_voltage_mv_i <= t.rest_mv;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every result beat taken is checked against the oldest prediction.
  always @(posedge clk_i) begin : collect_reports
    nicd_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("result beat arrived with no tick waiting for it");
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("stage", want.stage, stage_o);
          check_field("cell_kind", want.kind, cell_kind_o);
          check_field("pack_cells", want.cells, pack_cells_o);
          check_field("charge_phase", want.phase, charge_phase_o);
          check_field("target_ma", want.target_ma, target_ma_o);
          check_field("adjust_request", want.adjust, adjust_request_o);
          check_field("pwm_action", want.pwm, pwm_action_o);
          check_field("peak_mv", want.peak_mv, peak_mv_o);
          check_field("dv_count", want.dv_count, dv_count_o);
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("nicd_charge_controller_test: errors");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle. The register takes the
  // value at the edge where psel and penable are both high.
  task automatic write_reg(input logic [2:0] idx, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      nicd_pkg::RegRemovalLow:
        cfg.removal_low_mv = value[nicd_pkg::MvW-1:0];
      nicd_pkg::RegRemovalHigh:
        cfg.removal_high_mv = value[nicd_pkg::MvW-1:0];
      nicd_pkg::RegPresence:
        cfg.presence_mv = value[nicd_pkg::MvW-1:0];
      nicd_pkg::RegPreCurrent:
        cfg.pre_current_ma = value[nicd_pkg::MaW-1:0];
      nicd_pkg::RegFastCurrent:
        cfg.fast_current_ma = value[nicd_pkg::MaW-1:0];
      nicd_pkg::RegStackPreCurrent:
        cfg.stack_pre_current_ma = value[nicd_pkg::MaW-1:0];
      nicd_pkg::RegStackFastCurrent:
        cfg.stack_fast_current_ma = value[nicd_pkg::MaW-1:0];
      default:
        cfg.dv_count_limit = value[nicd_pkg::CountW-1:0];
    endcase
  endtask

  task automatic apply_settings(input int low, input int high, input int presence,
                                input int pre, input int fast, input int stack_pre,
                                input int stack_fast, input int dv_limit);
    write_reg(nicd_pkg::RegRemovalLow, low);
    write_reg(nicd_pkg::RegRemovalHigh, high);
    write_reg(nicd_pkg::RegPresence, presence);
    write_reg(nicd_pkg::RegPreCurrent, pre);
    write_reg(nicd_pkg::RegFastCurrent, fast);
    write_reg(nicd_pkg::RegStackPreCurrent, stack_pre);
    write_reg(nicd_pkg::RegStackFastCurrent, stack_fast);
    write_reg(nicd_pkg::RegDvCountLimit, dv_limit);
  endtask

  // Wait until every tick is sent and every result beat has been checked,
  // then give the two pipeline registers time to settle.
  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int clip(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int rand_between(input int a, input int b);
    if (b <= a) return a;
    return a + int'($urandom_range(b - a));
  endfunction

  // Pull a voltage into the window where the cell does not count as removed,
  // when the current settings leave such a window at all.
  function automatic int clamp_mv(input int v);
    int lo;
    int hi;
    lo = cfg.removal_low_mv;
    hi = cfg.removal_high_mv;
    lo = lo + 1;
    hi = hi - 1;
    if (lo <= hi) begin
      if (v < lo) v = lo;
      if (v > hi) v = hi;
    end
    return clip(v, MaxMv);
  endfunction

  task automatic queue_tick(input int v, input int ma, input int rest);
    tick_t t;
    t.mv      = clip(v, MaxMv);
    t.ma      = clip(ma, MaxMa);
    t.rest_mv = clip(rest, MaxMv);
    tick_q.push_back(t);
    queued_ticks++;
  endtask

  task automatic queue_noise();
    queue_tick($urandom_range(MaxMv), $urandom_range(MaxMa), $urandom_range(MaxMv));
  endtask

  // One charge session from insertion to stop and restart: detect pulses,
  // presence, type and array sizing, pre-charge, a rising then falling fast
  // charge, rest samples in stop, and sometimes a removal at the end.
  task automatic queue_session();
    int cells;
    int v;
    int tgt;
    int thr;
    int low;
    low = cfg.removal_low_mv;
    case ($urandom_range(3))
      0:       cells = 1;
      1:       cells = 2;
      2:       cells = 4;
      default: cells = 7;
    endcase
    // Most sessions begin with the cell pulled out, which clears the state.
    if ($urandom_range(9) < 8) queue_tick(rand_between(0, low), $urandom_range(MaxMa),
                                          $urandom_range(MaxMv));
    repeat ($urandom_range(2)) queue_tick(clamp_mv(rand_between(0, cfg.presence_mv - 1)),
                                          $urandom_range(MaxMa), $urandom_range(MaxMv));
    queue_tick(clamp_mv(rand_between(cfg.presence_mv, cfg.presence_mv + 300)),
               $urandom_range(MaxMa), $urandom_range(MaxMv));
    if ($urandom_range(5) == 0) queue_tick(clamp_mv(rand_between(SingleMaxMv, ArrayMinMv - 1)),
                                           $urandom_range(MaxMa), $urandom_range(MaxMv));
    if (cells == 1) begin
      queue_tick(clamp_mv(rand_between(600, SingleMaxMv - 1)), $urandom_range(MaxMa),
                 $urandom_range(MaxMv));
    end else begin
      queue_tick(clamp_mv(rand_between(ArrayMinMv, 3500)), $urandom_range(MaxMa),
                 $urandom_range(MaxMv));
      if ($urandom_range(9) == 0) begin
        // A pack that sags below the array minimum is rejected.
        queue_tick(clamp_mv(rand_between(0, ArrayMinMv - 1)), $urandom_range(MaxMa),
                   $urandom_range(MaxMv));
      end else begin
        case (cells)
          2:       v = rand_between(ArrayMinMv, FourMinMv - 1);
          4:       v = rand_between(FourMinMv, SevenMinMv - 1);
          default: v = rand_between(SevenMinMv, 9500);
        endcase
        queue_tick(clamp_mv(v), $urandom_range(MaxMa), $urandom_range(MaxMv));
      end
    end
    // Pre-charge with the current near its target, then a rest sample high
    // enough to move on to fast charge.
    thr = PreMvPerCell * cells;
    tgt = (cells == 7) ? cfg.stack_pre_current_ma : cfg.pre_current_ma;
    repeat ($urandom_range(3)) queue_tick(clamp_mv(1200 * cells + $urandom_range(80)),
                                          rand_between(tgt - 50, tgt + 50),
                                          rand_between(0, thr - 1));
    queue_tick(clamp_mv(1250 * cells), rand_between(tgt - 50, tgt + 50),
               rand_between(thr, thr + 600));
    v = 1350 * cells;
    repeat (rand_between(2, 12)) begin
      v = v + $urandom_range(8);
      queue_tick(clamp_mv(v), $urandom_range(MaxMa), $urandom_range(MaxMv));
    end
    repeat (rand_between(2, 20)) begin
      v = v - $urandom_range(12);
      if ($urandom_range(7) == 0) v = v + $urandom_range(30);
      queue_tick(clamp_mv(v), $urandom_range(MaxMa), $urandom_range(MaxMv));
    end
    // Rest samples: a few above the restart level, then one below it.
    repeat ($urandom_range(3)) queue_tick(clamp_mv(v), $urandom_range(MaxMa),
                                          rand_between(RestartMvPerCell * cells,
                                                       RestartMvPerCell * cells + 800));
    queue_tick(clamp_mv(v), $urandom_range(MaxMa), rand_between(0, RestartMvPerCell * cells - 1));
    repeat ($urandom_range(4)) queue_tick(clamp_mv(v - $urandom_range(20)), $urandom_range(MaxMa),
                                          $urandom_range(MaxMv));
    if ($urandom_range(1) == 1) begin
      if ($urandom_range(1) == 1) queue_tick(rand_between(0, low), $urandom_range(MaxMa),
                                             $urandom_range(MaxMv));
      else queue_tick(rand_between(cfg.removal_high_mv, MaxMv), $urandom_range(MaxMa),
                      $urandom_range(MaxMv));
    end
  endtask

  task automatic queue_mix(input int count);
    int goal;
    goal = queued_ticks + count;
    while (queued_ticks < goal) begin
      if ($urandom_range(99) < 80) queue_session();
      else queue_noise();
    end
  endtask

  task automatic random_settings();
    apply_settings($urandom_range(300), rand_between(8000, MaxMv), $urandom_range(1500),
                   $urandom_range(MaxMa), $urandom_range(MaxMa), $urandom_range(MaxMa),
                   $urandom_range(MaxMa), $urandom_range(15));
  endtask

  initial begin
    cfg.removal_low_mv        = 14'd50;
    cfg.removal_high_mv       = 14'd5100;
    cfg.presence_mv           = 14'd500;
    cfg.pre_current_ma        = 12'd350;
    cfg.fast_current_ma       = 12'd1600;
    cfg.stack_pre_current_ma  = 12'd30;
    cfg.stack_fast_current_ma = 12'd80;
    cfg.dv_count_limit        = 4'd3;
    clear_charger();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk under the reset settings. Both removal limits, both
    // boundaries, detect pulses, a type tick between the single-cell and
    // array levels, the current tolerance edges, fast-charge entry, -dV
    // counting to a stop, rest above and below the restart level, and a pack
    // that is detected and then pulled out.
    queue_tick(0, 0, 0);
    queue_tick(MaxMv, MaxMa, MaxMv);
    queue_tick(50, 100, 100);
    queue_tick(51, 0, 0);
    queue_tick(499, 0, 0);
    queue_tick(500, 0, 0);
    queue_tick(1700, 0, 0);
    queue_tick(1499, 0, 0);
    queue_tick(1300, 0, 100);
    queue_tick(1300, 350, 1000);
    queue_tick(1310, 380, 1279);
    queue_tick(1320, 381, 1280);
    queue_tick(1330, MaxMa, 0);
    queue_tick(1340, 0, 0);
    queue_tick(1330, 0, 0);
    queue_tick(1329, 0, 0);
    queue_tick(1320, 0, 0);
    queue_tick(1300, 0, 0);
    queue_tick(1290, 0, 0);
    queue_tick(1290, 0, 1400);
    queue_tick(1290, 0, 1319);
    queue_tick(5100, 0, 0);
    queue_tick(2500, 0, 0);
    queue_tick(1800, 0, 0);
    queue_tick(MaxMv, 0, MaxMv);
    queue_mix(150);
    drain();

    // Wide-open removal window so that seven-cell stacks are reachable, with
    // extreme currents and a -dV limit that the saturating count never exceeds.
    apply_settings(0, MaxMv, 0, 0, MaxMa, MaxMa, 0, 15);
    queue_mix(220);
    drain();

    // No idling on either side, and the quickest possible stop on -dV.
    calm = 1'b1;
    apply_settings(50, MaxMv, 500, 350, 1600, 30, 80, 0);
    queue_mix(220);
    drain();
    calm = 1'b0;

    // Random settings; halfway through, the sender pauses until every
    // result has come back, with the charger left mid-session.
    random_settings();
    queue_mix(110);
    drain();
    queue_mix(110);
    drain();

    // Every voltage counts as removed.
    apply_settings(MaxMv, 0, MaxMv, MaxMa, 0, 0, MaxMa, 0);
    repeat (40) queue_noise();
    drain();

    random_settings();
    queue_mix(220);
    drain();

    random_settings();
    queue_mix(200);
    drain();

    if (mismatch_count == 0) begin
      $display("nicd_charge_controller_test: clean");
    end else begin
      $display("nicd_charge_controller_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nicd_pkg.sv
hw/rtl/nicd_regs.sv
hw/rtl/nicd_step.sv
hw/rtl/nicd_charge_controller.sv
dv/nicd_charge_controller_test.sv
